### hw/rtl/psps_pkg.sv
// Shared constants and types for the periodic sigmoid pulse stimulus block.
package psps_pkg;

  localparam int TIME_W    = 32;   // input time width
  localparam int PER_W     = 16;   // period / offset / duration width
  localparam int CFG_W     = 24;   // widest register, config data width
  localparam int IDX_W     = 3;    // config register index width
  localparam int ARG_W     = 42;   // edge argument width (24 x 18 signed)
  localparam int Q_W       = 31;   // Q2.30 value width (0 .. 2^30)
  localparam int TERMS     = 12;   // Taylor terms of e^-f
  localparam int NEXP      = 31;   // max count of e^-1 steps
  localparam int DIV_STEPS = 31;   // quotient bits of the logistic divide

  // Logistic unit latency: abs, series, combine, e^-1 steps, setup, divide
  localparam int LOG_LAT = 1 + 3 * TERMS + 1 + NEXP + 1 + DIV_STEPS;

  localparam logic [Q_W-1:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [28:0]    EXP_M1_Q30 = 29'd395007542;

  // floor(2^34 / k), used for the exact divide of a series term by k
  localparam logic [33:0] RECIP_TBL [TERMS+1] = '{
    34'd0,
    34'd0,
    34'(35'd17179869184 / 35'd2),
    34'(35'd17179869184 / 35'd3),
    34'(35'd17179869184 / 35'd4),
    34'(35'd17179869184 / 35'd5),
    34'(35'd17179869184 / 35'd6),
    34'(35'd17179869184 / 35'd7),
    34'(35'd17179869184 / 35'd8),
    34'(35'd17179869184 / 35'd9),
    34'(35'd17179869184 / 35'd10),
    34'(35'd17179869184 / 35'd11),
    34'(35'd17179869184 / 35'd12)
  };

  typedef enum logic [IDX_W-1:0] {
    REG_PERIOD   = 3'd0,
    REG_OFFSET   = 3'd1,
    REG_DURATION = 3'd2,
    REG_STEEP    = 3'd3,
    REG_AMP      = 3'd4,
    REG_CUTOFF   = 3'd5
  } cfg_reg_t;

endpackage

### hw/rtl/psps_if.sv
// Stream interfaces for the time input and the current output.
interface psps_in_if
  import psps_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] time_ms;
  modport source (output valid, output time_ms, input ready);
  modport sink (input valid, input time_ms, output ready);
endinterface

interface psps_out_if
  import psps_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [CFG_W-1:0] current;
  modport source (output valid, output current, input ready);
  modport sink (input valid, input current, output ready);
endinterface

### hw/rtl/periodic_sigmoid_pulse_stimulus.sv
// Top level of the periodic sigmoid pulse stimulus generator.
// Usage:
//   in_ch carries a simulation time in whole milliseconds; out_ch returns
//   one stimulus current (Q16.8 pA) per input transaction, in order.
//   The current is -amplitude / ((1+e^a)(1+e^b)) for the phase of the time
//   within the pacing period, or zero when either edge argument is above
//   the cutoff register.
//   cfg_we/cfg_idx/cfg_data write one register per cycle; write only while
//   no transaction is in flight.
// Timing:
//   One transaction per cycle while out_ch takes results. The path from input
//   acceptance to output valid is: 32 modulo steps, one argument multiply, the
//   101-stage logistic unit (12-term series, up to 31 e^-1 steps, 31-step
//   divide), then product, scale and output register.
// Reset:
//   rst_n (synchronous, active low) empties the pipeline and loads the
//   register defaults.
// Stall:
//   When out_ch is not ready with a result waiting, the whole pipeline
//   holds and in_ch.ready drops; nothing is lost or repeated.
module periodic_sigmoid_pulse_stimulus
  import psps_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  psps_in_if.sink          in_ch,
  psps_out_if.source       out_ch,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int LAT     = TIME_W + 1 + LOG_LAT + 3;
  localparam int CUT_LEN = LOG_LAT + 2;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [PER_W-1:0]  rem;
  } md_t;

  // configuration registers
  logic [PER_W-1:0]        period_r, off_r, dur_r;
  logic signed [CFG_W-1:0] steep_r, amp_r, cut_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= 16'd1000;
      off_r    <= '0;
      dur_r    <= 16'd1;
      steep_r  <= 24'sd65536;
      amp_r    <= '0;
      cut_r    <= 24'sd1310720;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_PERIOD:   period_r <= cfg_data[PER_W-1:0];
        REG_OFFSET:   off_r    <= cfg_data[PER_W-1:0];
        REG_DURATION: dur_r    <= cfg_data[PER_W-1:0];
        REG_STEEP:    steep_r  <= cfg_data;
        REG_AMP:      amp_r    <= cfg_data;
        REG_CUTOFF:   cut_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless a result is stuck
  logic           adv;
  logic [LAT-1:0] vld_r;

  assign adv         = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // time modulo period, one bit per stage
  logic [PER_W-1:0] per;
  md_t              md_in [TIME_W];
  md_t              md_r  [TIME_W];

  assign per      = (period_r == '0) ? PER_W'(1) : period_r;
  assign md_in[0] = '{t: in_ch.time_ms, rem: '0};

  for (genvar j = 0; j < TIME_W; j++) begin : g_mod
    logic [PER_W:0] r2, nr;
    if (j > 0) begin : g_link
      assign md_in[j] = md_r[j-1];
    end
    assign r2 = {md_in[j].rem, md_in[j].t[TIME_W-1]};
    assign nr = (r2 >= {1'b0, per}) ? r2 - {1'b0, per} : r2;
    always_ff @(posedge clk) begin
      if (adv) begin
        md_r[j] <= '{t: md_in[j].t << 1, rem: nr[PER_W-1:0]};
      end
    end
  end

  // edge arguments
  logic [PER_W-1:0]        phase;
  logic signed [PER_W+1:0] da, db;
  logic signed [ARG_W-1:0] a_r, b_r;

  assign phase = md_r[TIME_W-1].rem;
  assign da = signed'({2'b00, off_r}) - signed'({2'b00, phase});
  assign db = signed'({2'b00, phase}) - signed'({2'b00, off_r}) - signed'({2'b00, dur_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= ARG_W'(steep_r) * ARG_W'(da);
      b_r <= ARG_W'(steep_r) * ARG_W'(db);
    end
  end

  // cutoff flag rides alongside the logistic units
  logic               cut_now;
  logic [CUT_LEN-1:0] cutd_r;

  assign cut_now = (a_r > ARG_W'(cut_r)) || (b_r > ARG_W'(cut_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      cutd_r <= {cutd_r[CUT_LEN-2:0], cut_now};
    end
  end

  logic [Q_W-1:0] ga, gb;

  psps_logistic #(.FRAC_BITS(FRAC_BITS)) u_ga (.clk(clk), .en(adv), .x(a_r), .g(ga));
  psps_logistic #(.FRAC_BITS(FRAC_BITS)) u_gb (.clk(clk), .en(adv), .x(b_r), .g(gb));

  // product of the edge gains ga and gb, then amplitude scaling
  logic [2*Q_W-1:0]       pprod;
  logic [Q_W-1:0]         p_r;
  logic [CFG_W-1:0]       amag, m_r, res;
  logic [CFG_W+Q_W-1:0]   mprod;

  assign pprod = (2*Q_W)'(ga) * (2*Q_W)'(gb);
  assign amag  = amp_r[CFG_W-1] ? CFG_W'(-amp_r) : CFG_W'(amp_r);
  assign mprod = (CFG_W+Q_W)'(amag) * (CFG_W+Q_W)'(p_r) + (CFG_W+Q_W)'(ONE_Q30 >> 1);

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r <= pprod[2*Q_W-2:30];
      m_r <= mprod[CFG_W+29:30];
    end
  end

  // sign, saturation and cutoff into the output register
  assign res = amp_r[CFG_W-1] ? ((m_r > 24'h7F_FFFF) ? 24'h7F_FFFF : m_r) : CFG_W'(-m_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.current <= cutd_r[CUT_LEN-1] ? '0 : signed'(res);
    end
  end

  assign out_ch.valid = vld_r[LAT-1];

endmodule

### hw/rtl/psps_logistic.sv
// Pipelined 1/(1+e^x) in Q2.30 for a signed fixed-point argument.
module psps_logistic
  import psps_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ARG_W-1:0] x,
  output logic [Q_W-1:0]          g
);

  typedef struct packed {
    logic [Q_W:0]           ev;
    logic [Q_W:0]           od;
    logic [FRAC_BITS-1:0]   f;
    logic [4:0]             n;
    logic                   big;
    logic                   neg;
  } side_t;

  typedef struct packed {
    logic [4:0] n;
    logic       big;
    logic       neg;
  } esd_t;

  typedef struct packed {
    logic [Q_W:0]   rem;
    logic [Q_W-1:0] low;
    logic [Q_W:0]   d;
    logic [Q_W-1:0] q;
  } div_t;

  logic [ARG_W-1:0] mag;
  logic [Q_W-1:0]   tm_r [TERMS+1];
  side_t            sd_r [TERMS+1];

  // magnitude split into integer and fraction
  assign mag = x[ARG_W-1] ? ARG_W'(-x) : ARG_W'(x);

  always_ff @(posedge clk) begin
    if (en) begin
      tm_r[0] <= ONE_Q30;
      sd_r[0] <= '{ev: {1'b0, ONE_Q30}, od: '0, f: mag[FRAC_BITS-1:0],
                   n: mag[FRAC_BITS+4:FRAC_BITS], big: |mag[ARG_W-1:FRAC_BITS+5],
                   neg: x[ARG_W-1]};
    end
  end

  // Taylor series of e^-f, three stages per term
  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    localparam logic [Q_W-1:0] KV = Q_W'(k);
    logic [Q_W+FRAC_BITS-1:0] fprod;
    logic [Q_W+33:0]          rprod;
    logic [Q_W-1:0]           pf_a_r, pf_b_r, q0_b_r, q0, rmd, tnew;
    logic [Q_W:0]             ev_n, od_n;
    side_t                    sd_a_r, sd_b_r;

    assign fprod = (Q_W+FRAC_BITS)'(tm_r[k-1]) * (Q_W+FRAC_BITS)'(sd_r[k-1].f);

    always_ff @(posedge clk) begin
      if (en) begin
        pf_a_r <= fprod[Q_W+FRAC_BITS-1:FRAC_BITS];
        sd_a_r <= sd_r[k-1];
      end
    end

    // reciprocal estimate, at most one low
    assign rprod = (Q_W+34)'(pf_a_r) * (Q_W+34)'(RECIP_TBL[k]);
    assign q0    = (k == 1) ? pf_a_r : rprod[Q_W+33:34];

    always_ff @(posedge clk) begin
      if (en) begin
        pf_b_r <= pf_a_r;
        q0_b_r <= q0;
        sd_b_r <= sd_a_r;
      end
    end

    // correct the quotient and accumulate
    assign rmd  = pf_b_r - q0_b_r * KV;
    assign tnew = (rmd >= KV) ? q0_b_r + Q_W'(1) : q0_b_r;
    assign od_n = (k % 2 == 1) ? sd_b_r.od + (Q_W+1)'(tnew) : sd_b_r.od;
    assign ev_n = (k % 2 == 0) ? sd_b_r.ev + (Q_W+1)'(tnew) : sd_b_r.ev;

    always_ff @(posedge clk) begin
      if (en) begin
        tm_r[k] <= tnew;
        sd_r[k] <= '{ev: ev_n, od: od_n, f: sd_b_r.f, n: sd_b_r.n,
                     big: sd_b_r.big, neg: sd_b_r.neg};
      end
    end
  end

  // even minus odd, floored at zero, capped at one
  logic [Q_W:0]   diff;
  logic [Q_W-1:0] ex_r [NEXP+1];
  esd_t           es_r [NEXP+1];

  assign diff = (sd_r[TERMS].ev > sd_r[TERMS].od) ?
                sd_r[TERMS].ev - sd_r[TERMS].od : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r[0] <= (diff > {1'b0, ONE_Q30}) ? ONE_Q30 : diff[Q_W-1:0];
      es_r[0] <= '{n: sd_r[TERMS].n, big: sd_r[TERMS].big, neg: sd_r[TERMS].neg};
    end
  end

  // one rounded multiply by e^-1 per stage while the count lasts
  for (genvar i = 1; i <= NEXP; i++) begin : g_exp
    logic [Q_W+28:0] eprod;
    assign eprod = (Q_W+29)'(ex_r[i-1]) * (Q_W+29)'(EXP_M1_Q30) +
                   (Q_W+29)'(ONE_Q30 >> 1);
    always_ff @(posedge clk) begin
      if (en) begin
        ex_r[i] <= (es_r[i-1].n >= 5'(i)) ? Q_W'(eprod[Q_W+28:30]) : ex_r[i-1];
        es_r[i] <= es_r[i-1];
      end
    end
  end

  // divider setup
  logic [Q_W-1:0]   e_val;
  logic [2*Q_W-2:0] num;
  div_t             dv_r [DIV_STEPS+1];

  assign e_val = es_r[NEXP].big ? '0 : ex_r[NEXP];
  assign num   = es_r[NEXP].neg ? (2*Q_W-1)'(1) << 60 : (2*Q_W-1)'(e_val) << 30;

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= '{rem: (Q_W+1)'(num[2*Q_W-2:Q_W]), low: num[Q_W-1:0],
                   d: (Q_W+1)'(ONE_Q30) + (Q_W+1)'(e_val), q: '0};
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [Q_W+1:0] rem2, nrem;
    logic           ge;
    assign rem2 = {dv_r[j-1].rem, dv_r[j-1].low[Q_W-1]};
    assign ge   = rem2 >= {1'b0, dv_r[j-1].d};
    assign nrem = ge ? rem2 - {1'b0, dv_r[j-1].d} : rem2;
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[j] <= '{rem: nrem[Q_W:0], low: dv_r[j-1].low << 1, d: dv_r[j-1].d,
                     q: {dv_r[j-1].q[Q_W-2:0], ge}};
      end
    end
  end

  assign g = dv_r[DIV_STEPS].q;

endmodule

### tb/sv/psps_tb_if.sv
// Testbench constants: long receiver hold-off length and watchdog limit.
package psps_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LONG = 400;   // long receiver hold-off, cycles
  localparam int WATCHDOG   = 20000; // cycles without any transaction
endpackage

### tb/sv/periodic_sigmoid_pulse_stimulus_test.sv
// Self-checking testbench for the periodic sigmoid pulse stimulus block.
module periodic_sigmoid_pulse_stimulus_test;
  import psps_pkg::*;
  import psps_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam longint unsigned ONE30 = 64'd1 << 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  psps_in_if in_ch ();
  psps_out_if out_ch ();

  periodic_sigmoid_pulse_stimulus #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the register file
  logic [15:0] period_r, offset_r, dur_r;
  logic signed [23:0] steep_r, amp_r, cut_r;

  logic signed [23:0] current_q[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  // e^-y in Q2.30 for y >= 0 with FB fraction bits
  function automatic longint unsigned exp_neg_q30(longint unsigned y);
    longint unsigned n, f, term, even, odd, r;
    if (y >= (longint'(32) << FB)) return 0;
    n = y >> FB;
    f = y & ((64'd1 << FB) - 1);
    term = ONE30;
    even = ONE30;
    odd = 0;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * f) >> FB) / k;
      if (k % 2 == 1) odd += term;
      else even += term;
    end
    r = (even > odd) ? even - odd : 0;
    if (r > ONE30) r = ONE30;
    for (longint unsigned i = 0; i < n; i++)
      r = (r * 64'd395007542 + (ONE30 >> 1)) >> 30;
    return r;
  endfunction

  // 1/(1+e^x) in Q2.30
  function automatic longint unsigned edge_gain(longint signed x);
    longint unsigned e;
    e = exp_neg_q30(x >= 0 ? x : -x);
    if (x >= 0) return (e << 30) / (ONE30 + e);
    return (ONE30 << 30) / (ONE30 + e);
  endfunction

  function automatic logic signed [23:0] stim_current(logic [31:0] t);
    longint signed per, ph, a, b, amp;
    longint unsigned p, amag, m;
    per = (period_r == 0) ? 1 : period_r;
    ph = longint'({32'd0, t}) % per;
    a = longint'(steep_r) * (longint'(offset_r) - ph);
    b = longint'(steep_r) * (ph - longint'(offset_r) - longint'(dur_r));
    if (a > longint'(cut_r) || b > longint'(cut_r)) return '0;
    p = (edge_gain(a) * edge_gain(b)) >> 30;
    amp = amp_r;
    amag = amp < 0 ? -amp : amp;
    m = (amag * p + (ONE30 >> 1)) >> 30;
    if (amp < 0) begin
      if (m > 64'd8388607) m = 64'd8388607;
      return 24'(m);
    end
    return 24'(-longint'(m));
  endfunction

  // receiver ready, with random stalls and a forced hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic signed [23:0] exp_cur;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (current_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected current %0d", out_ch.current);
      end else begin
        exp_cur = current_q.pop_front();
        if (out_ch.current !== exp_cur) begin
          mismatches++;
          if (mismatches <= 10)
            $display("current mismatch: expected %0d actual %0d", exp_cur, out_ch.current);
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // valid stays high between back-to-back transactions
  task automatic send_time(logic [31:0] t);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.time_ms <= t;
    do @(posedge clk); while (!in_ch.ready);
    current_q.push_back(stim_current(t));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (current_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_PERIOD: period_r = val[15:0];
      REG_OFFSET: offset_r = val[15:0];
      REG_DURATION: dur_r = val[15:0];
      REG_STEEP: steep_r = val;
      REG_AMP: amp_r = val;
      REG_CUTOFF: cut_r = val;
      default: ;
    endcase
  endtask

  task automatic set_pulse(logic [15:0] per, logic [15:0] off, logic [15:0] dur,
                           logic [23:0] st, logic [23:0] amp, logic [23:0] cut);
    drain();
    write_reg(REG_PERIOD, {8'd0, per});
    write_reg(REG_OFFSET, {8'd0, off});
    write_reg(REG_DURATION, {8'd0, dur});
    write_reg(REG_STEEP, st);
    write_reg(REG_AMP, amp);
    write_reg(REG_CUTOFF, cut);
    cfg_we <= 1'b0;
  endtask

  // extremes of time and registers, zero period, cutoff
  task automatic test_directed();
    send_time(32'd0);
    send_time(32'd1);
    set_pulse(16'd1000, 16'd100, 16'd200, 24'sd65536, 24'sd25600, 24'sd1310720);
    send_time(32'd100);
    send_time(32'd200);
    send_time(32'd300);
    send_time(32'hFFFF_FFFF);
    set_pulse(16'd0, 16'd0, 16'd0, 24'sd0, -24'sd8388608, 24'sd0);
    send_time(32'd12345);   // zero period, p = 1/4
    set_pulse(16'd10, 16'd0, 16'd65535, 24'sh800000, -24'sd8388608, 24'sh7FFFFF);
    send_time(32'd0);       // b edge above the cutoff
    send_time(32'd7);
    set_pulse(16'd65535, 16'd65535, 16'd65535, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    send_time(32'd65534);   // edge cut off
    send_time(32'hAAAA_5555);
    set_pulse(16'd100, 16'd20, 16'd30, 24'sd4096, 24'sh7FFFFF, 24'sh7FFFFF);
    for (int t = 15; t < 60; t += 5) send_time(t);
    set_pulse(16'd100, 16'd20, 16'd30, -24'sd300, 24'sd1234, 24'sh7FFFFF);
    send_time(32'd25);
    send_time(32'd80);
  endtask

  task automatic random_pulse();
    logic [15:0] per;
    per = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(400));
    set_pulse(per, 16'($urandom_range(per)), 16'($urandom_range(per)),
              ($urandom_range(7) == 0) ? 24'($urandom) : 24'($urandom_range(262144)),
              24'($urandom),
              ($urandom_range(5) == 0) ? 24'($urandom) : 24'sh7FFFFF);
  endtask

  task automatic test_random(int items);
    for (int i = 0; i < items; i++) begin
      if (i % 150 == 0) random_pulse();
      send_time(($urandom_range(3) == 0) ? $urandom : $urandom_range(2000));
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_cycles <= STALL_LONG;
    for (int i = 0; i < 200; i++) send_time($urandom);
    drain();
    for (int i = 0; i < 20; i++) send_time($urandom_range(1000));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.time_ms = '0;
    out_ch.ready = 1'b0;
    period_r = 16'd1000;
    offset_r = 16'd0;
    dur_r = 16'd1;
    steep_r = 24'sd65536;
    amp_r = 24'sd0;
    cut_r = 24'sd1310720;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle = 31;
    recv_idle = 55;
    test_random(650);
    send_idle = 55;
    recv_idle = 31;
    test_random(650);
    send_idle = 0;
    recv_idle = 0;
    test_random(400);
    test_backpressure();
    drain();
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
